// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

   // Default queue depth in words
   localparam int DEPTH_DEFAULT = 1024;

   // Word width of stored values and result data
   localparam int WORD_W = 32;

   // Opcode width and codes
   localparam int OPCODE_W = 3;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SIZE       = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_EMPTY      = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_FRONT      = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_BACK       = 3'd7;

   // Answer for a pop or peek on an empty queue
   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   // Slot memory port control
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Response stage flags
   typedef struct packed {
      logic valid;
      logic use_ram;
      logic has_data;
      logic overflow;
   } rsp_info_type;

endpackage

// File: rtl/double_ended_queue.sv
// A request accepted at one clock edge gets its result strobed in the next cycle.
// One request is taken per cycle; busy stays low, as each request is a single
// access to the one-port slot memory plus a head/count update.
// Reset clears head and count, leaving the queue empty; slot contents are not cleared.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps

module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dq_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic signed [dq_pkg::WORD_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic signed [dq_pkg::WORD_W-1:0]  rsp_data,
   output logic                              rsp_has_data,
   output logic                              rsp_overflow
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic                      accept;
   dq_pkg::mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0]         mem_addr;
   logic [dq_pkg::WORD_W-1:0] rd_data;
   dq_pkg::rsp_info_type      rsp_info;
   logic [dq_pkg::WORD_W-1:0] rsp_imm;
   logic [CNT_W-1:0]          count;

   // Every request completes in one memory access, so the queue never holds off
   assign busy   = 1'b0;
   assign accept = start && !busy;

   dq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .opcode  (req_opcode),
      .mem_ctl (mem_ctl),
      .mem_addr(mem_addr),
      .rsp_info(rsp_info),
      .rsp_imm (rsp_imm),
      .count   (count)
   );

   dq_ram #(
      .WIDTH(dq_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (mem_ctl.wr_en),
      .rd_en  (mem_ctl.rd_en),
      .addr   (mem_addr),
      .wr_data(req_value),
      .rd_data(rd_data)
   );

   // Result: slot word for successful pops and peeks, else the registered answer
   assign rsp_valid    = rsp_info.valid;
   assign rsp_data     = rsp_info.use_ram ? rd_data : rsp_imm;
   assign rsp_has_data = rsp_info.has_data;
   assign rsp_overflow = rsp_info.overflow;

   // Each result comes in the cycle after an accepted request
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without a request in the previous cycle");

   // Occupancy stays within the ring
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("item count above depth");

   // A dropped push only happens on a full queue, which it leaves full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (count == CNT_W'(DEPTH) && !rsp_has_data))
      else $error("overflow flagged while queue not full");

   // An empty-queue pop or peek leaves the count at zero
   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && count == '0 && !mem_ctl.rd_en) |=> (count == '0 || $past(mem_ctl.wr_en)))
      else $error("count changed without a push on an empty queue");

endmodule

// File: rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [dq_pkg::OPCODE_W-1:0]   opcode,
   output dq_pkg::mem_ctl_type           mem_ctl,
   output logic [$clog2(DEPTH)-1:0]      mem_addr,
   output dq_pkg::rsp_info_type          rsp_info,
   output logic [dq_pkg::WORD_W-1:0]     rsp_imm,
   output logic [$clog2(DEPTH+1)-1:0]    count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff;
   logic              use_ram_ff, use_ram_in;
   logic              has_data_ff, has_data_in;
   logic              overflow_ff, overflow_in;
   logic [dq_pkg::WORD_W-1:0] imm_ff, imm_in;

   logic              empty, full;
   logic [ADDR_W-1:0] head_dec, head_inc, tail_pos, back_pos;
   logic [SUM_W-1:0]  tail_sum, back_sum;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] addr;

   // Occupancy and ring positions, each wrap is one compare and subtract
   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == CNT_W'(DEPTH));
      head_dec = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);
      head_inc = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      back_sum = tail_sum - SUM_W'(1);
      tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                             : ADDR_W'(tail_sum);
      back_pos = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                             : ADDR_W'(back_sum);
   end

   // Opcode decode: slot access, pointer update, immediate answer
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      addr        = head_ff;
      overflow_in = 1'b0;
      imm_in      = '0;
      has_data_in = !(opcode inside {dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK});
      case (opcode)
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               overflow_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               addr     = head_dec;
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               overflow_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               addr     = tail_pos;
               count_in = count_ff + CNT_W'(1);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            imm_in = dq_pkg::EMPTY_WORD;
            if (!empty) begin
               rd_en    = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         dq_pkg::OP_POP_BACK: begin
            imm_in = dq_pkg::EMPTY_WORD;
            if (!empty) begin
               rd_en    = 1'b1;
               addr     = back_pos;
               count_in = count_ff - CNT_W'(1);
            end
         end
         dq_pkg::OP_SIZE: begin
            imm_in = dq_pkg::WORD_W'(count_ff);
         end
         dq_pkg::OP_EMPTY: begin
            imm_in = dq_pkg::WORD_W'(empty);
         end
         dq_pkg::OP_FRONT: begin
            imm_in = dq_pkg::EMPTY_WORD;
            rd_en  = !empty;
         end
         dq_pkg::OP_BACK: begin
            imm_in = dq_pkg::EMPTY_WORD;
            rd_en  = !empty;
            addr   = back_pos;
         end
         default: begin
            imm_in = '0;
         end
      endcase
      use_ram_in = rd_en;
   end

   // Pointer state and response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
      if (accept) begin
         use_ram_ff  <= use_ram_in;
         has_data_ff <= has_data_in;
         overflow_ff <= overflow_in;
         imm_ff      <= imm_in;
      end
   end

   assign mem_ctl.wr_en     = accept && wr_en;
   assign mem_ctl.rd_en     = accept && rd_en;
   assign mem_addr          = addr;
   assign rsp_info.valid    = valid_ff;
   assign rsp_info.use_ram  = use_ram_ff;
   assign rsp_info.has_data = has_data_ff;
   assign rsp_info.overflow = overflow_ff;
   assign rsp_imm           = imm_ff;
   assign count             = count_ff;

endmodule
